@@ rtl/core/assert_macros.svh @@
// Shared assertion macros for the bus frame encoder core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPLIES(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/bfe_pkg.sv @@
package bfe_pkg;

   // Input item operations
   localparam logic OP_START = 1'b0;
   localparam logic OP_DATA  = 1'b1;

   // Frame kinds
   localparam logic KIND_ADDR = 1'b0;
   localparam logic KIND_BOOT = 1'b1;

   // Header flag on the node byte and base of the checksum
   localparam logic [7:0] ADDR_FLAG = 8'd128;
   localparam logic [7:0] CK_BASE   = 8'd128;
   localparam logic [7:0] RAW_LIMIT = 8'd127;

   // Depth of the job queue between front and back
   localparam int JOB_QUEUE_DEPTH = 4;

   // One output beat
   typedef struct packed {
      logic [7:0] line_byte;
      logic       frame_done;
      logic       rejected;
   } bfe_beat_type;

   // All beats caused by one input item; last is the index of the final beat
   typedef struct packed {
      logic [1:0]             last;
      bfe_beat_type [3:0]     beat;
   } bfe_job_type;

endpackage

@@ rtl/core/bus_frame_encoder_core.sv @@
// Bus frame encoder core: turns start and payload items into serial bus frame bytes.
// Input queue side: drive req_* and raise req_push; the item is taken at a rising
// edge with req_push high and req_full low. A start item (req_op 0) opens a frame
// and yields its header; a payload item (req_op 1) yields its byte, plus the
// checksum after the last byte. A refused start yields one beat with rsp_rejected.
// Result queue side: while rsp_empty is low the oldest beat is on rsp_*; it is taken
// at a rising edge with rsp_pop high. rsp_run_end marks the last beat of an item.
// csr_wr_en writes csr_boot_mode at the next edge; write it only while idle.
// The first beat of an item reaches the ports through the job queue and the output register.
// The back end emits one beat per cycle while jobs wait and the receiver pops; a payload
// item yields one beat (two with its checksum) and a start item one to four beats; the front
// takes one item per cycle while the 4-entry job queue has room.
// A stalled receiver holds the output beat; the job queue then fills and raises
// req_full. Synchronous reset empties the queue and output stage, closes any open
// frame and clears boot mode.
module bus_frame_encoder_core
   import bfe_pkg::*;
#(
   parameter int NUM_NODES = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic       csr_boot_mode,
   input  logic       req_push,
   output logic       req_full,
   input  logic       req_op,
   input  logic       req_frame_kind,
   input  logic [7:0] req_dest_node,
   input  logic [7:0] req_payload_len,
   input  logic       req_is_text,
   input  logic [7:0] req_payload_byte,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_line_byte,
   output logic       rsp_frame_done,
   output logic       rsp_rejected,
   output logic       rsp_run_end
);

   logic        queue_full;
   logic        job_push;
   bfe_job_type push_job;
   logic        job_valid;
   bfe_job_type head_job;
   logic        job_pop;

   assign req_full = queue_full;

   // Classify items and track the open frame
   bfe_front #(
      .NUM_NODES (NUM_NODES)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_boot_mode    (csr_boot_mode),
      .req_push         (req_push),
      .queue_full       (queue_full),
      .req_op           (req_op),
      .req_frame_kind   (req_frame_kind),
      .req_dest_node    (req_dest_node),
      .req_payload_len  (req_payload_len),
      .req_is_text      (req_is_text),
      .req_payload_byte (req_payload_byte),
      .job_push         (job_push),
      .job              (push_job)
   );

   // Decouple front and back
   bfe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_job  (push_job),
      .pop       (job_pop),
      .full      (queue_full),
      .not_empty (job_valid),
      .head_job  (head_job)
   );

   // Emit beats one per cycle while the receiver pops
   bfe_back u_back (
      .clock          (clock),
      .reset          (reset),
      .job_valid      (job_valid),
      .job            (head_job),
      .job_pop        (job_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_line_byte  (rsp_line_byte),
      .rsp_frame_done (rsp_frame_done),
      .rsp_rejected   (rsp_rejected),
      .rsp_run_end    (rsp_run_end)
   );

endmodule

@@ rtl/core/bfe_front.sv @@
`include "assert_macros.svh"

module bfe_front
   import bfe_pkg::*;
#(
   parameter int NUM_NODES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_boot_mode,
   input  logic        req_push,
   input  logic        queue_full,
   input  logic        req_op,
   input  logic        req_frame_kind,
   input  logic [7:0]  req_dest_node,
   input  logic [7:0]  req_payload_len,
   input  logic        req_is_text,
   input  logic [7:0]  req_payload_byte,
   output logic        job_push,
   output bfe_job_type job
);

   localparam logic [7:0] NODE_LIMIT = 8'(NUM_NODES);

   logic       boot_mode_ff;
   logic       frame_active_ff, frame_active_in;
   logic [7:0] bytes_left_ff, bytes_left_in;
   logic [6:0] running_sum_ff, running_sum_in;

   logic       accept;
   logic       start_ok;
   logic       len_zero;
   logic       last_data;
   logic       job_has;
   logic [6:0] start_sum;
   logic [6:0] data_sum;
   logic [7:0] start_ck;
   logic [7:0] data_ck;

   assign accept = req_push & ~queue_full;

   // Classify the start beat
   always_comb begin
      if (req_frame_kind == KIND_ADDR) begin
         start_ok  = (req_dest_node < NODE_LIMIT) &&
                     (req_is_text ? !req_payload_len[7] : (req_payload_len < RAW_LIMIT));
         start_sum = req_dest_node[6:0] + req_payload_len[6:0];
      end else begin
         start_ok  = boot_mode_ff & ~req_payload_len[7];
         start_sum = req_payload_len[6:0];
      end
   end

   assign len_zero  = (req_payload_len == 8'd0);
   assign start_ck  = CK_BASE - {1'b0, start_sum};
   assign data_sum  = running_sum_ff + req_payload_byte[6:0];
   assign data_ck   = CK_BASE - {1'b0, data_sum};
   assign last_data = (bytes_left_ff == 8'd1);

   // Build the beat list for this item
   always_comb begin
      job     = '0;
      job_has = 1'b0;
      if (req_op == OP_START) begin
         job_has = 1'b1;
         if (!start_ok) begin
            job.beat[0].rejected = 1'b1;
            job.last             = 2'd0;
         end else if (req_frame_kind == KIND_ADDR) begin
            job.beat[0].line_byte = req_dest_node + ADDR_FLAG;
            job.beat[1].line_byte = req_payload_len;
            if (req_is_text) begin
               job.beat[2].line_byte  = start_ck;
               job.beat[2].frame_done = 1'b1;
               job.last               = len_zero ? 2'd2 : 2'd1;
            end else begin
               job.beat[2].line_byte  = 8'd0;
               job.beat[3].line_byte  = start_ck;
               job.beat[3].frame_done = 1'b1;
               job.last               = len_zero ? 2'd3 : 2'd2;
            end
         end else begin
            job.beat[0].line_byte  = req_payload_len;
            job.beat[1].line_byte  = start_ck;
            job.beat[1].frame_done = 1'b1;
            job.last               = len_zero ? 2'd1 : 2'd0;
         end
      end else if (frame_active_ff) begin
         job_has                = 1'b1;
         job.beat[0].line_byte  = req_payload_byte;
         job.beat[1].line_byte  = data_ck;
         job.beat[1].frame_done = 1'b1;
         job.last               = last_data ? 2'd1 : 2'd0;
      end
   end

   assign job_push = accept & job_has;

   // Advance the frame state
   always_comb begin
      frame_active_in = frame_active_ff;
      bytes_left_in   = bytes_left_ff;
      running_sum_in  = running_sum_ff;
      if (accept) begin
         if (req_op == OP_START) begin
            frame_active_in = start_ok & ~len_zero;
            bytes_left_in   = start_ok ? req_payload_len : 8'd0;
            running_sum_in  = start_ok ? start_sum : 7'd0;
         end else if (frame_active_ff) begin
            frame_active_in = ~last_data;
            bytes_left_in   = bytes_left_ff - 8'd1;
            running_sum_in  = data_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         boot_mode_ff    <= 1'b0;
         frame_active_ff <= 1'b0;
         bytes_left_ff   <= 8'd0;
         running_sum_ff  <= 7'd0;
      end else begin
         if (csr_wr_en) begin
            boot_mode_ff <= csr_boot_mode;
         end
         frame_active_ff <= frame_active_in;
         bytes_left_ff   <= bytes_left_in;
         running_sum_ff  <= running_sum_in;
      end
   end

   `ASSERT_IMPLIES(a_reject_single, clock, reset, job_push && job.beat[0].rejected, job.last == 2'd0, "rejection job carries more than one beat")
   `ASSERT_IMPLIES(a_open_nonzero, clock, reset, frame_active_ff, bytes_left_ff != 8'd0, "open frame with no bytes left")

endmodule

@@ rtl/core/bfe_queue.sv @@
`include "assert_macros.svh"

module bfe_queue
   import bfe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  bfe_job_type push_job,
   input  logic        pop,
   output logic        full,
   output logic        not_empty,
   output bfe_job_type head_job
);

   localparam int PTR_W = $clog2(JOB_QUEUE_DEPTH);
   localparam int CNT_W = $clog2(JOB_QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(JOB_QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(JOB_QUEUE_DEPTH);

   bfe_job_type       slot_ff [JOB_QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_pop;

   assign full      = (count_ff == CNT_FULL);
   assign not_empty = (count_ff != '0);
   assign head_job  = slot_ff[rd_ptr_ff];
   assign do_pop    = pop & not_empty;

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold job storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   `ASSERT_IMPLIES(a_no_overflow, clock, reset, full, !push, "job pushed into a full queue")
   `ASSERT_IMPLIES(a_count_range, clock, reset, 1'b1, count_ff <= CNT_FULL, "queue count out of range")

endmodule

@@ rtl/core/bfe_back.sv @@
`include "assert_macros.svh"

module bfe_back
   import bfe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        job_valid,
   input  bfe_job_type job,
   output logic        job_pop,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_line_byte,
   output logic        rsp_frame_done,
   output logic        rsp_rejected,
   output logic        rsp_run_end
);

   logic [1:0]   beat_idx_ff, beat_idx_in;
   logic         out_valid_ff, out_valid_in;
   bfe_beat_type out_beat_ff;
   logic         out_run_end_ff;
   logic         load;
   logic         at_last;

   assign load    = job_valid & (~out_valid_ff | rsp_pop);
   assign at_last = (beat_idx_ff == job.last);
   assign job_pop = load & at_last;

   // Step through the beats of the head job
   always_comb begin
      beat_idx_in  = beat_idx_ff;
      out_valid_in = out_valid_ff;
      if (load) begin
         beat_idx_in  = at_last ? 2'd0 : beat_idx_ff + 2'd1;
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_idx_ff  <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         beat_idx_ff  <= beat_idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Load the output beat
   always_ff @(posedge clock) begin
      if (load) begin
         out_beat_ff    <= job.beat[beat_idx_ff];
         out_run_end_ff <= at_last;
      end
   end

   assign rsp_empty      = ~out_valid_ff;
   assign rsp_line_byte  = out_beat_ff.line_byte;
   assign rsp_frame_done = out_beat_ff.frame_done;
   assign rsp_rejected   = out_beat_ff.rejected;
   assign rsp_run_end    = out_run_end_ff;

   `ASSERT_IMPLIES(a_idx_in_job, clock, reset, job_valid, beat_idx_ff <= job.last, "beat index past end of job")
   `ASSERT_NEXT(a_done_ends_run, clock, reset, load && job.beat[beat_idx_ff].frame_done, rsp_run_end, "checksum beat not last of its run")

endmodule

@@ dv/tb.sv @@
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bfe_pkg::*;

   localparam int NODE_COUNT      = 64;
   localparam int IDLE_LIMIT      = 1000;
   localparam int HOLD_OFF_CYCLES = 60;
   localparam int DRAIN_CYCLES    = 8;
   localparam int REPORT_MAX      = 10;
   localparam int PHASE_ITEMS     = 20;

   typedef enum logic {CHK_MODEL, CHK_REJECT} row_check_type;

   // One row of the directed table; wr_boot writes boot_val before the item
   typedef struct packed {
      logic          wr_boot;
      logic          boot_val;
      logic          op;
      logic          kind;
      logic [7:0]    node;
      logic [7:0]    len;
      logic          text;
      logic [7:0]    pbyte;
      row_check_type chk;
   } stim_row_type;

   typedef struct packed {
      logic [7:0] line_byte;
      logic       frame_done;
      logic       rejected;
      logic       run_end;
   } line_beat_type;

   localparam int N_ROWS = 25;
   localparam stim_row_type DIRECTED_ROWS [N_ROWS] = '{
      // boot frame right after reset: boot mode is off
      '{1'b0, 1'b0, OP_START, KIND_BOOT, 8'd0,   8'd4,   1'b0, 8'h00, CHK_REJECT},
      // payload with no open frame
      '{1'b0, 1'b0, OP_DATA,  KIND_ADDR, 8'd0,   8'd0,   1'b0, 8'h55, CHK_MODEL},
      // broadcast, zero length, raw
      '{1'b0, 1'b0, OP_START, KIND_ADDR, 8'd0,   8'd0,   1'b0, 8'h00, CHK_MODEL},
      // longest raw frame, then abandoned by a refused start
      '{1'b0, 1'b0, OP_START, KIND_ADDR, 8'd63,  8'd126, 1'b0, 8'h00, CHK_MODEL},
      '{1'b0, 1'b0, OP_START, KIND_ADDR, 8'd64,  8'd1,   1'b0, 8'h00, CHK_REJECT},
      '{1'b0, 1'b0, OP_DATA,  KIND_ADDR, 8'd0,   8'd0,   1'b0, 8'h33, CHK_MODEL},
      '{1'b0, 1'b0, OP_START, KIND_ADDR, 8'd255, 8'd0,   1'b1, 8'h00, CHK_REJECT},
      '{1'b0, 1'b0, OP_START, KIND_ADDR, 8'd1,   8'd127, 1'b0, 8'h00, CHK_REJECT},
      '{1'b0, 1'b0, OP_START, KIND_ADDR, 8'd2,   8'd255, 1'b1, 8'h00, CHK_REJECT},
      // longest text frame, abandoned by the next start
      '{1'b0, 1'b0, OP_START, KIND_ADDR, 8'd3,   8'd127, 1'b1, 8'h00, CHK_MODEL},
      '{1'b0, 1'b0, OP_START, KIND_ADDR, 8'd10,  8'd2,   1'b1, 8'h00, CHK_MODEL},
      '{1'b0, 1'b0, OP_DATA,  KIND_ADDR, 8'd0,   8'd0,   1'b0, 8'hff, CHK_MODEL},
      '{1'b0, 1'b0, OP_DATA,  KIND_ADDR, 8'd0,   8'd0,   1'b0, 8'h00, CHK_MODEL},
      '{1'b0, 1'b0, OP_START, KIND_ADDR, 8'd0,   8'd3,   1'b0, 8'h00, CHK_MODEL},
      '{1'b0, 1'b0, OP_DATA,  KIND_ADDR, 8'd0,   8'd0,   1'b0, 8'h80, CHK_MODEL},
      '{1'b0, 1'b0, OP_DATA,  KIND_ADDR, 8'd0,   8'd0,   1'b0, 8'h7f, CHK_MODEL},
      '{1'b0, 1'b0, OP_DATA,  KIND_ADDR, 8'd0,   8'd0,   1'b0, 8'haa, CHK_MODEL},
      // boot mode on: zero length boot frame, over-long one, longest one, then a short one
      '{1'b1, 1'b1, OP_START, KIND_BOOT, 8'd0,   8'd0,   1'b0, 8'h00, CHK_MODEL},
      '{1'b0, 1'b0, OP_START, KIND_BOOT, 8'd0,   8'd128, 1'b0, 8'h00, CHK_REJECT},
      '{1'b0, 1'b0, OP_START, KIND_BOOT, 8'd255, 8'd127, 1'b1, 8'h00, CHK_MODEL},
      '{1'b0, 1'b0, OP_START, KIND_BOOT, 8'd99,  8'd2,   1'b0, 8'h00, CHK_MODEL},
      '{1'b0, 1'b0, OP_DATA,  KIND_ADDR, 8'd0,   8'd0,   1'b0, 8'h01, CHK_MODEL},
      '{1'b0, 1'b0, OP_DATA,  KIND_ADDR, 8'd0,   8'd0,   1'b0, 8'hfe, CHK_MODEL},
      // addressed frames still pass in boot mode
      '{1'b0, 1'b0, OP_START, KIND_ADDR, 8'd63,  8'd1,   1'b0, 8'h00, CHK_MODEL},
      '{1'b0, 1'b0, OP_DATA,  KIND_ADDR, 8'd0,   8'd0,   1'b0, 8'h12, CHK_MODEL}
   };

   logic       clock;
   logic       reset            = 1'b1;
   logic       csr_wr_en        = 1'b0;
   logic       csr_boot_mode    = 1'b0;
   logic       req_push         = 1'b0;
   logic       req_full;
   logic       req_op           = 1'b0;
   logic       req_frame_kind   = 1'b0;
   logic [7:0] req_dest_node    = 8'h00;
   logic [7:0] req_payload_len  = 8'h00;
   logic       req_is_text      = 1'b0;
   logic [7:0] req_payload_byte = 8'h00;
   logic       rsp_empty;
   logic       rsp_pop          = 1'b0;
   logic [7:0] rsp_line_byte;
   logic       rsp_frame_done;
   logic       rsp_rejected;
   logic       rsp_run_end;

   // Encoder state as seen by the predictor
   logic       boot_on  = 1'b0;
   logic       frm_open = 1'b0;
   logic [7:0] frm_left = 8'h00;
   logic [6:0] frm_sum  = 7'h00;

   line_beat_type step_beats [4];
   int            step_n;
   line_beat_type line_beats_due [$];

   int fail_count    = 0;
   int counted_items = 0;
   int hold_off_reqs = 0;
   bit send_gaps_on  = 1'b1;
   bit recv_gaps_on  = 1'b1;

   bus_frame_encoder_core #(.NUM_NODES(NODE_COUNT)) uut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_boot_mode    (csr_boot_mode),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_op           (req_op),
      .req_frame_kind   (req_frame_kind),
      .req_dest_node    (req_dest_node),
      .req_payload_len  (req_payload_len),
      .req_is_text      (req_is_text),
      .req_payload_byte (req_payload_byte),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_line_byte    (rsp_line_byte),
      .rsp_frame_done   (rsp_frame_done),
      .rsp_rejected     (rsp_rejected),
      .rsp_run_end      (rsp_run_end)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic void add_beat(logic [7:0] b, logic done, logic rej);
      step_beats[step_n] = '{b, done, rej, 1'b0};
      step_n++;
   endfunction

   // Emit a header or payload byte and fold it into the 7-bit frame sum
   function automatic void add_summed(logic [7:0] b);
      frm_sum = frm_sum + b[6:0];
      add_beat(b, 1'b0, 1'b0);
   endfunction

   function automatic void close_with_checksum();
      add_beat(CK_BASE - {1'b0, frm_sum}, 1'b1, 1'b0);
      frm_open = 1'b0;
      frm_left = 8'h00;
   endfunction

   // Work out the line beats one accepted item produces
   function automatic void encode_item(input logic op, input logic kind,
                                       input logic [7:0] node, input logic [7:0] len,
                                       input logic text, input logic [7:0] pbyte);
      logic ok;
      step_n = 0;
      if (op == OP_START) begin
         frm_open = 1'b0;
         frm_left = 8'h00;
         frm_sum  = 7'h00;
         if (kind == KIND_ADDR) begin
            ok = (int'(node) < NODE_COUNT) && (int'(len) < int'(RAW_LIMIT) + int'(text));
         end else begin
            ok = boot_on && !len[7];
         end
         if (!ok) begin
            add_beat(8'h00, 1'b0, 1'b1);
         end else begin
            if (kind == KIND_ADDR) begin
               add_summed(node + ADDR_FLAG);
               add_summed(len);
               if (!text) begin
                  add_summed(8'h00);
               end
            end else begin
               add_summed(len);
            end
            frm_open = 1'b1;
            frm_left = len;
            if (len == 8'h00) begin
               close_with_checksum();
            end
         end
      end else if (frm_open) begin
         add_summed(pbyte);
         frm_left = frm_left - 8'd1;
         if (frm_left == 8'h00) begin
            close_with_checksum();
         end
      end
      if (step_n > 0) begin
         step_beats[step_n - 1].run_end = 1'b1;
      end
   endfunction

   function automatic void note_failure(string msg);
      fail_count++;
      if (fail_count <= REPORT_MAX) begin
         $display("%0t: %s", $realtime, msg);
      end
   endfunction

   // Offer one item, hold it until taken, then queue its expected beats
   task automatic push_item(input logic op, input logic kind, input logic [7:0] node,
                            input logic [7:0] len, input logic text,
                            input logic [7:0] pbyte, input row_check_type chk);
      if (send_gaps_on && $urandom_range(0, 7) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_op           <= op;
      req_frame_kind   <= kind;
      req_dest_node    <= node;
      req_payload_len  <= len;
      req_is_text      <= text;
      req_payload_byte <= pbyte;
      req_push         <= 1'b1;
      do @(posedge clock); while (req_full);
      encode_item(op, kind, node, len, text, pbyte);
      if (chk == CHK_REJECT) begin
         line_beats_due.push_back('{8'h00, 1'b0, 1'b1, 1'b1});
      end else begin
         for (int i = 0; i < step_n; i++) begin
            line_beats_due.push_back(step_beats[i]);
         end
      end
      if (step_n > 0) begin
         counted_items++;
      end
   endtask

   // Drain, let the pipeline settle, then write boot mode
   task automatic set_boot_mode(input logic v);
      req_push <= 1'b0;
      while (line_beats_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_boot_mode <= v;
      csr_wr_en     <= 1'b1;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      boot_on = v;
   endtask

   // Receiver: check each popped beat, stall in bursts, hold off on request
   initial begin : receiver
      int            stall_left;
      int            hold_left;
      int            holds_done;
      line_beat_type got;
      line_beat_type want;
      stall_left = 0;
      hold_left  = 0;
      holds_done = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) begin
            got = '{rsp_line_byte, rsp_frame_done, rsp_rejected, rsp_run_end};
            if (line_beats_due.size() == 0) begin
               note_failure($sformatf("unexpected beat: byte %0d done %0b rej %0b end %0b",
                  got.line_byte, got.frame_done, got.rejected, got.run_end));
            end else begin
               want = line_beats_due.pop_front();
               if (got.line_byte !== want.line_byte || got.frame_done !== want.frame_done ||
                   got.rejected !== want.rejected || got.run_end !== want.run_end) begin
                  note_failure({
                     $sformatf("beat mismatch: exp byte %0d done %0b rej %0b end %0b",
                        want.line_byte, want.frame_done, want.rejected, want.run_end),
                     $sformatf(", got byte %0d done %0b rej %0b end %0b",
                        got.line_byte, got.frame_done, got.rejected, got.run_end)});
               end
            end
         end
         if (hold_off_reqs != holds_done) begin
            holds_done = hold_off_reqs;
            hold_left  = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_pop <= 1'b0;
         end else if (recv_gaps_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 14) - 1;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // Watchdog: end the run when no beat moves on either side for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("** bus_frame_encoder_core: FAILED **");
      $finish;
   end

   initial begin : stimulus
      stim_row_type row;
      int           r;
      int           n_data;
      int           phase_target;
      logic         kind;
      logic [7:0]   len;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed table
      for (int i = 0; i < N_ROWS; i++) begin
         row = DIRECTED_ROWS[i];
         if (row.wr_boot) begin
            set_boot_mode(row.boot_val);
         end
         push_item(row.op, row.kind, row.node, row.len, row.text, row.pbyte, row.chk);
      end

      // Random phases, boot mode alternating; last phase runs without idling
      for (int ph = 0; ph < 4; ph++) begin
         set_boot_mode(ph[0]);
         if (ph == 1) begin
            hold_off_reqs++;
         end
         if (ph == 3) begin
            send_gaps_on = 1'b0;
            recv_gaps_on = 1'b0;
         end
         phase_target = counted_items + PHASE_ITEMS;
         while (counted_items < phase_target) begin
            r = $urandom_range(0, 9);
            if (r < 7) begin
               // well-formed frame, sometimes cut short
               kind = (boot_on && $urandom_range(0, 2) == 0) ? KIND_BOOT : KIND_ADDR;
               len  = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(6, 24))
                                                   : 8'($urandom_range(0, 5));
               push_item(OP_START, kind, 8'($urandom_range(0, NODE_COUNT - 1)), len,
                         1'($urandom), 8'($urandom), CHK_MODEL);
               n_data = int'(len);
               if (len != 8'h00 && $urandom_range(0, 9) == 0) begin
                  n_data = $urandom_range(0, int'(len) - 1);
               end
               repeat (n_data) begin
                  push_item(OP_DATA, 1'($urandom), 8'($urandom), 8'($urandom), 1'($urandom),
                            8'($urandom), CHK_MODEL);
               end
            end else if (r < 9) begin
               // noise start with any field values
               push_item(OP_START, 1'($urandom), 8'($urandom), 8'($urandom), 1'($urandom),
                         8'($urandom), CHK_MODEL);
            end else begin
               push_item(OP_DATA, 1'($urandom), 8'($urandom), 8'($urandom), 1'($urandom),
                         8'($urandom), CHK_MODEL);
            end
         end
      end

      // Wait out the remaining beats
      req_push <= 1'b0;
      while (line_beats_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && line_beats_due.size() == 0) begin
         $display("** bus_frame_encoder_core: PASSED **");
      end else begin
         $display("** bus_frame_encoder_core: FAILED **");
      end
      $finish;
   end

endmodule
